>>> design/cpsp_pkg.sv
// Package for the CPU stack push/pop unit.
// Holds the item types, the controller-to-datapath command struct, opcode codes and flag helpers.
// Depends on nothing.
`default_nettype none

package cpsp_pkg;

  typedef struct packed {
    logic        action;
    logic [7:0]  opcode;
    logic [3:0]  reg_select;
    logic [15:0] reg_value;
  } in_t;

  typedef struct packed {
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [7:0]  status_byte;
    logic [15:0] stack_ptr;
    logic [15:0] prog_counter;
    logic [31:0] cycle_total;
    logic        bad_opcode;
  } out_t;

  typedef struct packed {
    logic latch;
    logic mem_wr;
    logic mem_rd;
    logic sel_hi;
    logic cap_lo;
    logic push_commit;
    logic pop_commit;
    logic load_commit;
    logic finish;
    logic bad;
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_PUSH,
    KIND_POP,
    KIND_BAD
  } kind_e;

  localparam logic        ACTION_LOAD  = 1'b1;
  localparam logic [7:0]  OP_PAIR_MASK = 8'hCF;
  localparam logic [7:0]  OP_PUSH      = 8'hC5;
  localparam logic [7:0]  OP_POP       = 8'hC1;
  localparam logic [1:0]  PAIR_PSW     = 2'd3;

  localparam logic [2:0]  IDX_B = 3'd0;
  localparam logic [2:0]  IDX_C = 3'd1;
  localparam logic [2:0]  IDX_D = 3'd2;
  localparam logic [2:0]  IDX_E = 3'd3;
  localparam logic [2:0]  IDX_H = 3'd4;
  localparam logic [2:0]  IDX_L = 3'd5;
  localparam logic [2:0]  IDX_A = 3'd6;
  localparam int          NUM_REGS = 7;

  localparam logic [3:0]  SEL_LAST_BYTE = 4'd6;
  localparam logic [3:0]  SEL_FLAGS     = 4'd7;
  localparam logic [3:0]  SEL_SP        = 4'd8;

  localparam logic [31:0] PUSH_CYCLES = 32'd11;
  localparam logic [31:0] POP_CYCLES  = 32'd10;
  localparam logic [7:0]  FLAGS_FIXED = 8'h02;

  function automatic kind_e decode_kind(input logic action, input logic [7:0] opcode);
    kind_e k;
    if (action == ACTION_LOAD) begin
      k = KIND_LOAD;
    end else if ((opcode & OP_PAIR_MASK) == OP_PUSH) begin
      k = KIND_PUSH;
    end else if ((opcode & OP_PAIR_MASK) == OP_POP) begin
      k = KIND_POP;
    end else begin
      k = KIND_BAD;
    end
    return k;
  endfunction

  // Flag order inside the five-bit register: cy, p, ac, z, s from bit 0 up.
  function automatic logic [7:0] pack_flags(input logic [4:0] f);
    return {f[4], f[3], 1'b0, f[2], 1'b0, f[1], 1'b0, f[0]} | FLAGS_FIXED;
  endfunction

  function automatic logic [4:0] unpack_flags(input logic [7:0] v);
    return {v[7], v[6], v[4], v[2], v[0]};
  endfunction

endpackage

`default_nettype wire

>>> design/cpu_stack_push_pop_unit.sv
// Top level of the CPU stack push/pop unit.
// Instantiates cpsp_ctrl and cpsp_dpath; uses cpsp_pkg.
//
// An item is taken when start_i is high while busy_o is low. A push keeps the block busy while
// it writes the high and then the low byte to the single-port stack memory; a pop keeps it busy
// for the low read, the high read and a last state in which the registered read data reaches the
// registers; a load or an unknown opcode passes only through EXEC. The result appears on result_o
// with done_o high for exactly one cycle, the cycle after busy_o falls, and must be taken then
// since it cannot be held off. A new item may be started in that same cycle. The stack memory
// has no reset: popping a byte that was never pushed returns whatever the memory holds.
`default_nettype none

module cpu_stack_push_pop_unit #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cpsp_pkg::in_t in_i,
  output logic               busy_o,
  output logic               done_o,
  output cpsp_pkg::out_t     result_o
);

  cpsp_pkg::cmd_t cmd;

  cpsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (in_i.action),
    .opcode_i (in_i.opcode),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  cpsp_dpath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

>>> design/cpsp_ctrl.sv
// Controller state machine of the CPU stack push/pop unit.
// Sequences memory accesses and register updates; uses cpsp_pkg.
`default_nettype none

module cpsp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          action_i,
  input  wire logic [7:0]    opcode_i,
  output logic               busy_o,
  output cpsp_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    PUSH_HI,
    PUSH_LO,
    POP_LO,
    POP_HI,
    POP_END,
    EXEC
  } state_e;

  state_e          state_q;
  cpsp_pkg::cmd_t  cmd_q;
  cpsp_pkg::kind_e kind;
  logic            accept;

  assign kind   = cpsp_pkg::decode_kind(action_i, opcode_i);
  assign busy_o = (state_q != IDLE);
  assign accept = start_i && (state_q == IDLE);

  always_comb begin
    cmd_o       = cmd_q;
    cmd_o.latch = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cmd_q   <= '0;
    end else begin
      cmd_q <= '0;
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            unique case (kind)
              cpsp_pkg::KIND_PUSH: begin
                state_q       <= PUSH_HI;
                cmd_q.mem_wr  <= 1'b1;
                cmd_q.sel_hi  <= 1'b1;
              end
              cpsp_pkg::KIND_POP: begin
                state_q       <= POP_LO;
                cmd_q.mem_rd  <= 1'b1;
              end
              cpsp_pkg::KIND_LOAD: begin
                state_q           <= EXEC;
                cmd_q.load_commit <= 1'b1;
                cmd_q.finish      <= 1'b1;
              end
              cpsp_pkg::KIND_BAD: begin
                state_q      <= EXEC;
                cmd_q.bad    <= 1'b1;
                cmd_q.finish <= 1'b1;
              end
              default: state_q <= IDLE;
            endcase
          end
        end
        PUSH_HI: begin
          state_q           <= PUSH_LO;
          cmd_q.mem_wr      <= 1'b1;
          cmd_q.push_commit <= 1'b1;
          cmd_q.finish      <= 1'b1;
        end
        POP_LO: begin
          state_q      <= POP_HI;
          cmd_q.mem_rd <= 1'b1;
          cmd_q.sel_hi <= 1'b1;
          cmd_q.cap_lo <= 1'b1;
        end
        POP_HI: begin
          state_q          <= POP_END;
          cmd_q.pop_commit <= 1'b1;
          cmd_q.finish     <= 1'b1;
        end
        PUSH_LO, POP_END, EXEC: begin
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not make the block busy");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.finish |=> !busy_o)
    else $error("block stayed busy after finishing an item");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_q.mem_wr && cmd_q.mem_rd))
    else $error("memory read and write issued in the same cycle");

  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.pop_commit |-> $past(cmd_q.cap_lo))
    else $error("pop committed without capturing its low byte");
`endif

endmodule

`default_nettype wire

>>> design/cpsp_dpath.sv
// Datapath of the CPU stack push/pop unit: register file, flags, pointers and stack memory.
// Driven by cpsp_ctrl commands; uses cpsp_pkg.
`default_nettype none

module cpsp_dpath #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cpsp_pkg::in_t  in_i,
  input  wire cpsp_pkg::cmd_t cmd_i,
  output logic                done_o,
  output cpsp_pkg::out_t      result_o
);

  localparam int MemDepth = 1 << ADDR_BITS;

  cpsp_pkg::in_t item_q;
  logic [7:0]    regs_q [cpsp_pkg::NUM_REGS];
  logic [4:0]    flags_q;
  logic [15:0]   sp_q;
  logic [15:0]   pc_q;
  logic [31:0]   cyc_q;
  logic [7:0]    lo_q;
  logic [7:0]    rdata_q;
  logic          done_q;
  logic          bad_q;
  logic [7:0]    mem [MemDepth];

  logic [1:0]    pair;
  logic [2:0]    idx_hi;
  logic [2:0]    idx_lo;
  logic [7:0]    push_hi;
  logic [7:0]    push_lo;
  logic [7:0]    wdata;
  logic [15:0]   addr_full;
  logic [ADDR_BITS-1:0] addr;

  assign pair   = item_q.opcode[5:4];
  assign idx_hi = {pair, 1'b0};
  assign idx_lo = {pair, 1'b1};

  always_comb begin
    if (pair == cpsp_pkg::PAIR_PSW) begin
      push_hi = regs_q[cpsp_pkg::IDX_A];
      push_lo = cpsp_pkg::pack_flags(flags_q);
    end else begin
      push_hi = regs_q[idx_hi];
      push_lo = regs_q[idx_lo];
    end
  end

  always_comb begin
    priority if (cmd_i.mem_wr && cmd_i.sel_hi) begin
      addr_full = sp_q - 16'd1;
    end else if (cmd_i.mem_wr) begin
      addr_full = sp_q - 16'd2;
    end else if (cmd_i.sel_hi) begin
      addr_full = sp_q + 16'd1;
    end else begin
      addr_full = sp_q;
    end
  end

  assign addr  = addr_full[ADDR_BITS-1:0];
  assign wdata = cmd_i.sel_hi ? push_hi : push_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_i;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpsp_pkg::NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
      flags_q <= '0;
      sp_q    <= '0;
      pc_q    <= '0;
      cyc_q   <= '0;
      done_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        bad_q <= cmd_i.bad;
      end
      if (cmd_i.push_commit) begin
        sp_q  <= sp_q - 16'd2;
        pc_q  <= pc_q + 16'd1;
        cyc_q <= cyc_q + cpsp_pkg::PUSH_CYCLES;
      end
      if (cmd_i.pop_commit) begin
        if (pair == cpsp_pkg::PAIR_PSW) begin
          flags_q                  <= cpsp_pkg::unpack_flags(lo_q);
          regs_q[cpsp_pkg::IDX_A]  <= rdata_q;
        end else begin
          regs_q[idx_hi] <= rdata_q;
          regs_q[idx_lo] <= lo_q;
        end
        sp_q  <= sp_q + 16'd2;
        pc_q  <= pc_q + 16'd1;
        cyc_q <= cyc_q + cpsp_pkg::POP_CYCLES;
      end
      if (cmd_i.load_commit) begin
        if (item_q.reg_select <= cpsp_pkg::SEL_LAST_BYTE) begin
          regs_q[item_q.reg_select[2:0]] <= item_q.reg_value[7:0];
        end else if (item_q.reg_select == cpsp_pkg::SEL_FLAGS) begin
          flags_q <= cpsp_pkg::unpack_flags(item_q.reg_value[7:0]);
        end else if (item_q.reg_select == cpsp_pkg::SEL_SP) begin
          sp_q <= item_q.reg_value;
        end
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    result_o.reg_a        = regs_q[cpsp_pkg::IDX_A];
    result_o.reg_b        = regs_q[cpsp_pkg::IDX_B];
    result_o.reg_c        = regs_q[cpsp_pkg::IDX_C];
    result_o.reg_d        = regs_q[cpsp_pkg::IDX_D];
    result_o.reg_e        = regs_q[cpsp_pkg::IDX_E];
    result_o.reg_h        = regs_q[cpsp_pkg::IDX_H];
    result_o.reg_l        = regs_q[cpsp_pkg::IDX_L];
    result_o.status_byte  = cpsp_pkg::pack_flags(flags_q);
    result_o.stack_ptr    = sp_q;
    result_o.prog_counter = pc_q;
    result_o.cycle_total  = cyc_q;
    result_o.bad_opcode   = bad_q;
  end

`ifndef ASSERT_OFF
  a_push_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_commit |=> sp_q == $past(sp_q) - 16'd2)
    else $error("push did not lower the stack pointer by two");

  a_pop_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_commit |=> sp_q == $past(sp_q) + 16'd2)
    else $error("pop did not raise the stack pointer by two");

  a_bad_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bad |=> $stable(pc_q) && $stable(cyc_q) && $stable(sp_q))
    else $error("unknown opcode changed architectural state");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.finish))
    else $error("result strobe without a finished transfer");
`endif

endmodule

`default_nettype wire

>>> tb/sv/cpu_stack_push_pop_unit_checker.sv
// Checker for the CPU stack push/pop unit: predicts the register file after each accepted
// transfer and compares every result field against it. Depends on cpsp_pkg.
module cpu_stack_push_pop_unit_checker #(
  parameter int ADDR_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  cpsp_pkg::in_t    in_i,
  input  logic             done_i,
  input  cpsp_pkg::out_t   result_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cpsp_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  logic [7:0]  cpu_regs [NUM_REGS];
  logic [4:0]  flag_reg;
  logic [15:0] sp_reg;
  logic [15:0] pc_reg;
  logic [31:0] cycles_reg;
  logic [7:0]  stack_mem [MEM_DEPTH];

  out_t        expected_state_q [$];
  out_t        oldest;
  int unsigned fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [7:0] status_of(input logic [4:0] f);
    logic [7:0] s;
    s = FLAGS_FIXED;
    s[0] = f[0];
    s[2] = f[1];
    s[4] = f[2];
    s[6] = f[3];
    s[7] = f[4];
    return s;
  endfunction

  function automatic logic [4:0] flags_of(input logic [7:0] v);
    return {v[7], v[6], v[4], v[2], v[0]};
  endfunction

  function automatic int mem_slot(input logic [15:0] addr);
    return int'(addr) % MEM_DEPTH;
  endfunction

  function automatic kind_e classify(input in_t it);
    if (it.action == ACTION_LOAD) return KIND_LOAD;
    if ((it.opcode & OP_PAIR_MASK) == OP_PUSH) return KIND_PUSH;
    if ((it.opcode & OP_PAIR_MASK) == OP_POP) return KIND_POP;
    return KIND_BAD;
  endfunction

  function automatic out_t execute_item(input in_t it);
    out_t       r;
    logic [1:0] pair;
    logic [7:0] hi;
    logic [7:0] lo;
    pair = it.opcode[5:4];
    r = '0;
    case (classify(it))
      KIND_LOAD: begin
        if (it.reg_select <= SEL_LAST_BYTE) begin
          cpu_regs[it.reg_select[2:0]] = it.reg_value[7:0];
        end else if (it.reg_select == SEL_FLAGS) begin
          flag_reg = flags_of(it.reg_value[7:0]);
        end else if (it.reg_select == SEL_SP) begin
          sp_reg = it.reg_value;
        end
      end
      KIND_PUSH: begin
        if (pair == PAIR_PSW) begin
          hi = cpu_regs[IDX_A];
          lo = status_of(flag_reg);
        end else begin
          hi = cpu_regs[{pair, 1'b0}];
          lo = cpu_regs[{pair, 1'b1}];
        end
        stack_mem[mem_slot(sp_reg - 16'd1)] = hi;
        stack_mem[mem_slot(sp_reg - 16'd2)] = lo;
        sp_reg = sp_reg - 16'd2;
        pc_reg = pc_reg + 16'd1;
        cycles_reg = cycles_reg + PUSH_CYCLES;
      end
      KIND_POP: begin
        lo = stack_mem[mem_slot(sp_reg)];
        hi = stack_mem[mem_slot(sp_reg + 16'd1)];
        if (pair == PAIR_PSW) begin
          flag_reg = flags_of(lo);
          cpu_regs[IDX_A] = hi;
        end else begin
          cpu_regs[{pair, 1'b0}] = hi;
          cpu_regs[{pair, 1'b1}] = lo;
        end
        sp_reg = sp_reg + 16'd2;
        pc_reg = pc_reg + 16'd1;
        cycles_reg = cycles_reg + POP_CYCLES;
      end
      default: begin
        r.bad_opcode = 1'b1;
      end
    endcase
    r.reg_a = cpu_regs[IDX_A];
    r.reg_b = cpu_regs[IDX_B];
    r.reg_c = cpu_regs[IDX_C];
    r.reg_d = cpu_regs[IDX_D];
    r.reg_e = cpu_regs[IDX_E];
    r.reg_h = cpu_regs[IDX_H];
    r.reg_l = cpu_regs[IDX_L];
    r.status_byte = status_of(flag_reg);
    r.stack_ptr = sp_reg;
    r.prog_counter = pc_reg;
    r.cycle_total = cycles_reg;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) cpu_regs[k] = 8'h00;
      flag_reg = '0;
      sp_reg = '0;
      pc_reg = '0;
      cycles_reg = '0;
      expected_state_q.delete();
    end else begin
      if (done_i) begin
        if (expected_state_q.size() == 0) begin
          $display("%0t: result with no transfer outstanding, expected none, actual %h",
                   $time, result_i);
          fails++;
        end else begin
          oldest = expected_state_q.pop_front();
          check_field("reg_a", oldest.reg_a, result_i.reg_a);
          check_field("reg_b", oldest.reg_b, result_i.reg_b);
          check_field("reg_c", oldest.reg_c, result_i.reg_c);
          check_field("reg_d", oldest.reg_d, result_i.reg_d);
          check_field("reg_e", oldest.reg_e, result_i.reg_e);
          check_field("reg_h", oldest.reg_h, result_i.reg_h);
          check_field("reg_l", oldest.reg_l, result_i.reg_l);
          check_field("status_byte", oldest.status_byte, result_i.status_byte);
          check_field("stack_ptr", oldest.stack_ptr, result_i.stack_ptr);
          check_field("prog_counter", oldest.prog_counter, result_i.prog_counter);
          check_field("cycle_total", oldest.cycle_total, result_i.cycle_total);
          check_field("bad_opcode", oldest.bad_opcode, result_i.bad_opcode);
        end
      end
      if (start_i && !busy_i) begin
        expected_state_q.push_back(execute_item(in_i));
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_state_q.size();
  end

endmodule

>>> tb/sv/cpu_stack_push_pop_unit_tb.sv
// Top of the testbench for the CPU stack push/pop unit: clock, reset, directed and random
// instruction stimulus with varying idle rates, and the verdict.
// Depends on cpsp_pkg, cpu_stack_push_pop_unit and cpu_stack_push_pop_unit_checker.
module cpu_stack_push_pop_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpsp_pkg::*;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_RST7 = 8'hFF;
  localparam logic [3:0] SEL_TOP_CODE = 4'hF;
  localparam int unsigned ITEMS_PER_PHASE = 270;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  in_t         stim;
  logic        busy_o;
  logic        done_o;
  out_t        result_o;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned idle_pct = 0;
  int unsigned idle_plan [5] = '{0, 83, 17, 83, 0};
  logic [15:0] sp_track = '0;
  logic [15:0] stack_top = '0;
  bit          stack_written [65536];

  cpu_stack_push_pop_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (stim),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  cpu_stack_push_pop_unit_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .in_i        (stim),
    .done_i      (done_o),
    .result_i    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] pair_op(input logic [7:0] base, input logic [1:0] pair);
    return base | {2'b00, pair, 4'b0000};
  endfunction

  // Stack bytes are tracked so that a pop only ever reads bytes pushed since reset.
  function automatic in_t make_exec(input logic [7:0] op);
    in_t it;
    it.action = ~ACTION_LOAD;
    it.opcode = op;
    it.reg_select = 4'($urandom);
    it.reg_value = 16'($urandom);
    if ((op & OP_PAIR_MASK) == OP_PUSH) begin
      stack_written[16'(sp_track - 16'd1)] = 1'b1;
      stack_written[16'(sp_track - 16'd2)] = 1'b1;
      sp_track = sp_track - 16'd2;
      stack_top = sp_track;
    end else if ((op & OP_PAIR_MASK) == OP_POP) begin
      sp_track = sp_track + 16'd2;
    end
    return it;
  endfunction

  function automatic in_t make_load(input logic [3:0] sel, input logic [15:0] val);
    in_t it;
    it.action = ACTION_LOAD;
    it.opcode = 8'($urandom);
    it.reg_select = sel;
    it.reg_value = val;
    if (sel == SEL_SP) sp_track = val;
    return it;
  endfunction

  function automatic in_t random_item();
    int unsigned roll;
    logic [7:0]  op;
    logic [15:0] next_sp;
    roll = $urandom_range(99);
    if (roll < 66) begin
      if (roll >= 34 && stack_written[sp_track] && stack_written[16'(sp_track + 16'd1)]) begin
        return make_exec(pair_op(OP_POP, 2'($urandom)));
      end
      return make_exec(pair_op(OP_PUSH, 2'($urandom)));
    end
    if (roll < 80) return make_load(4'($urandom_range(SEL_LAST_BYTE)), 16'($urandom));
    if (roll < 84) return make_load(SEL_FLAGS, 16'($urandom));
    if (roll < 90) begin
      case ($urandom_range(3))
        0: next_sp = 16'($urandom);
        1: next_sp = $urandom_range(1) ? 16'h0000 - 16'($urandom_range(2))
                                       : 16'($urandom_range(1));
        default: next_sp = stack_top;
      endcase
      return make_load(SEL_SP, next_sp);
    end
    if (roll < 97) begin
      do begin
        op = 8'($urandom);
      end while ((op & OP_PAIR_MASK) == OP_PUSH || (op & OP_PAIR_MASK) == OP_POP);
      return make_exec(op);
    end
    return make_load(4'($urandom_range(SEL_TOP_CODE, SEL_SP + 4'd1)), 16'($urandom));
  endfunction

  task automatic send(input in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    stim <= it;
    @(posedge clk_i iff !busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i iff pending == 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    stim = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(make_exec(pair_op(OP_PUSH, PAIR_BC)));
    send(make_exec(pair_op(OP_POP, PAIR_BC)));
    send(make_load({1'b0, IDX_B}, 16'h12FF));
    send(make_load({1'b0, IDX_C}, 16'h3400));
    send(make_load({1'b0, IDX_D}, 16'h00AA));
    send(make_load({1'b0, IDX_E}, 16'hFF55));
    send(make_load({1'b0, IDX_H}, 16'h0001));
    send(make_load({1'b0, IDX_L}, 16'hFF80));
    send(make_load({1'b0, IDX_A}, 16'hFFFF));
    send(make_load(SEL_FLAGS, 16'h00FF));
    send(make_exec(pair_op(OP_PUSH, PAIR_PSW)));
    send(make_load(SEL_FLAGS, 16'hFF00));
    send(make_exec(pair_op(OP_POP, PAIR_PSW)));
    send(make_load(SEL_SP, 16'hFFFF));
    send(make_exec(pair_op(OP_PUSH, PAIR_DE)));
    send(make_exec(pair_op(OP_PUSH, PAIR_HL)));
    send(make_exec(pair_op(OP_POP, PAIR_DE)));
    send(make_exec(pair_op(OP_POP, PAIR_HL)));
    send(make_load(SEL_SP, 16'h0001));
    send(make_exec(pair_op(OP_PUSH, PAIR_PSW)));
    send(make_exec(pair_op(OP_POP, PAIR_BC)));
    send(make_exec(OP_NOP));
    send(make_exec(OP_RST7));
    send(make_load(SEL_TOP_CODE, 16'hFFFF));
    drain();

    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      repeat (ITEMS_PER_PHASE) send(random_item());
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** cpu_stack_push_pop_unit: PASSED **");
    end else begin
      $display("** cpu_stack_push_pop_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** cpu_stack_push_pop_unit: FAILED **");
    $finish;
  end

endmodule
